### hdl/fsrb_pkg.sv
// fsrb_pkg: sizes, codes and row types of the per-source reorder buffer
// no dependencies; imported by every module of the block
package fsrb_pkg;

    localparam int NUM_SOURCES   = 16;
    localparam int HOLD_DEPTH    = 8;
    localparam int PAYLOAD_BITS  = 16;

    localparam int SRC_BITS      = $clog2(NUM_SOURCES);
    localparam int SLOT_BITS     = $clog2(HOLD_DEPTH);
    localparam int SEQ_BITS      = 16;
    localparam int ROOM_BITS     = 4;
    localparam int ID_BITS       = 4;
    localparam int PORT_PAY_BITS = 16;

    typedef enum logic
    {
        OP_ARRIVE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_HELD  = 2'd1,
        ST_STALE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [SEQ_BITS-1:0]     seq;
        logic [ROOM_BITS-1:0]    room;
        logic [PAYLOAD_BITS-1:0] pay;
    } entry_t;

    typedef struct packed
    {
        logic [SEQ_BITS-1:0]   last_rel;
        logic [HOLD_DEPTH-1:0] vld;
        entry_t [HOLD_DEPTH-1:0] ent;
    } row_t;

    typedef struct packed
    {
        logic                 dup;
        logic                 free_any;
        logic [SLOT_BITS-1:0] free_idx;
        logic [SLOT_BITS-1:0] hit1_idx;
        logic                 hit2_any;
        logic                 any_valid;
        logic                 one_valid;
        logic [SLOT_BITS-1:0] min_idx;
    } scan_t;

endpackage

### hdl/fsrb_row_mem.sv
// fsrb_row_mem: one row per source (counter, slot valids, slot contents)
// synchronous memory with registered read; uses fsrb_pkg
module fsrb_row_mem
    import fsrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic                wr_en,
    input  logic [SRC_BITS-1:0] addr,
    input  row_t                wr_row,
    output row_t                rd_row
);

    row_t                   row_ram [NUM_SOURCES];
    row_t                   q_reg;
    logic                   qv_reg;
    logic [NUM_SOURCES-1:0] rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_ram[addr] <= wr_row;
        end
        if (rd_en)
        begin
            q_reg <= row_ram[addr];
        end
    end

    // a row never written reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= '0;
            qv_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                rvld_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                qv_reg <= rvld_reg[addr];
            end
        end
    end

    assign rd_row = qv_reg ? q_reg : '0;

endmodule

### hdl/fsrb_scan.sv
// fsrb_scan: parallel compare over the slots of the working row
// duplicate, free slot, next-in-sequence and smallest-distance search; uses fsrb_pkg
module fsrb_scan
    import fsrb_pkg::*;
(
    input  row_t                row,
    input  logic [SEQ_BITS-1:0] seq_in,
    output scan_t               scan
);

    logic [SEQ_BITS-1:0] want1;
    logic [SEQ_BITS-1:0] want2;
    logic [SEQ_BITS-1:0] gap;
    logic [SEQ_BITS-1:0] best;

    assign want1 = row.last_rel + SEQ_BITS'(1);
    assign want2 = row.last_rel + SEQ_BITS'(2);

    always_comb
    begin
        scan = '0;
        gap  = '0;
        best = '0;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (row.vld[i])
            begin
                if (row.ent[i].seq == seq_in)
                begin
                    scan.dup = 1'b1;
                end
                if (row.ent[i].seq == want1)
                begin
                    scan.hit1_idx = SLOT_BITS'(i);
                end
                if (row.ent[i].seq == want2)
                begin
                    scan.hit2_any = 1'b1;
                end
                gap = row.ent[i].seq - row.last_rel;
                if (!scan.any_valid || gap < best)
                begin
                    best         = gap;
                    scan.min_idx = SLOT_BITS'(i);
                end
                scan.any_valid = 1'b1;
            end
            else if (!scan.free_any)
            begin
                scan.free_any = 1'b1;
                scan.free_idx = SLOT_BITS'(i);
            end
        end
        scan.one_valid = ($countones(row.vld) == 1);
    end

endmodule

### hdl/fifo_sequence_reorder_buffer.sv
// fifo_sequence_reorder_buffer: top level, command channel and release sequencer
// uses fsrb_pkg, fsrb_row_mem and fsrb_scan
//
// usage
// - command channel: an item is taken at a clock edge with start high and busy low;
//   operation selects arrival or flush of source_id
// - result channel: one beat per cycle, marked by strobe; last flags the final
//   beat of an item; the receiver cannot hold beats off
// - an arrival gives one beat (held, stale or full; a duplicate is stale) or a run of
//   releases: the message itself and then its consecutive held successors
// - a flush releases the held messages of the source nearest first after the last
//   released sequence, or gives one empty beat, and clears the source counter
// - timing: the source row is read from a one-port memory (address state, then
//   load state) before the first beat is decided and registered
// - an item keeps busy high until its final beat is registered; when it is held, a
//   flush finds nothing or it releases messages (one beat per cycle), busy also
//   covers a write-back of the row that follows
// - reset clears all counters and holdback slots at once through per-row
//   valid flops; no clearing pass is needed
module fifo_sequence_reorder_buffer
    import fsrb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic [ID_BITS-1:0]       source_id,
    input  logic [SEQ_BITS-1:0]      sequence_req,
    input  logic [ROOM_BITS-1:0]     room,
    input  logic [PORT_PAY_BITS-1:0] payload,
    output logic                     strobe,
    output logic                     delivered,
    output logic [ROOM_BITS-1:0]     out_room,
    output logic [PORT_PAY_BITS-1:0] out_payload,
    output logic [SEQ_BITS-1:0]      out_sequence,
    output logic [1:0]               status,
    output logic                     last
);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_REJ   = 7'b0000010,
        S_RD    = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_CHAIN = 7'b0100000,
        S_FLUSH = 7'b1000000
    } state_t;

    logic                     wb_reg;
    logic                     wb_next;
    state_t                   state_reg;
    state_t                   state_next;
    op_t                      op_reg;
    op_t                      op_next;
    logic [SRC_BITS-1:0]      src_reg;
    logic [SRC_BITS-1:0]      src_next;
    logic [SEQ_BITS-1:0]      seq_reg;
    logic [SEQ_BITS-1:0]      seq_next;
    logic [ROOM_BITS-1:0]     room_reg;
    logic [ROOM_BITS-1:0]     room_next;
    logic [PAYLOAD_BITS-1:0]  pay_reg;
    logic [PAYLOAD_BITS-1:0]  pay_next;
    row_t                     row_reg;
    row_t                     row_next;

    logic                     strobe_reg;
    logic                     strobe_next;
    logic                     dlv_reg;
    logic                     dlv_next;
    logic [ROOM_BITS-1:0]     oroom_reg;
    logic [ROOM_BITS-1:0]     oroom_next;
    logic [PORT_PAY_BITS-1:0] opay_reg;
    logic [PORT_PAY_BITS-1:0] opay_next;
    logic [SEQ_BITS-1:0]      oseq_reg;
    logic [SEQ_BITS-1:0]      oseq_next;
    status_t                  ost_reg;
    status_t                  ost_next;
    logic                     olast_reg;
    logic                     olast_next;

    row_t                     rd_row;
    scan_t                    scan;
    logic [SEQ_BITS-1:0]      seq_gap;
    logic                     src_ok;
    entry_t                   new_ent;

    fsrb_row_mem u_mem
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (state_reg == S_RD),
        .wr_en  (wb_reg),
        .addr   (src_reg),
        .wr_row (row_reg),
        .rd_row (rd_row)
    );

    fsrb_scan u_scan
    (
        .row    (row_reg),
        .seq_in (seq_reg),
        .scan   (scan)
    );

    assign src_ok        = (32'(source_id) < 32'(NUM_SOURCES));
    assign seq_gap       = seq_reg - row_reg.last_rel;
    assign new_ent.seq   = seq_reg;
    assign new_ent.room  = room_reg;
    assign new_ent.pay   = pay_reg;

    always_comb
    begin
        state_next  = state_reg;
        wb_next     = 1'b0;
        op_next     = op_reg;
        src_next    = src_reg;
        seq_next    = seq_reg;
        room_next   = room_reg;
        pay_next    = pay_reg;
        row_next    = row_reg;
        strobe_next = 1'b0;
        dlv_next    = 1'b0;
        oroom_next  = '0;
        opay_next   = '0;
        oseq_next   = '0;
        ost_next    = ST_DONE;
        olast_next  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !wb_reg)
                begin
                    op_next    = op_t'(operation);
                    src_next   = SRC_BITS'(source_id);
                    seq_next   = sequence_req;
                    room_next  = room;
                    pay_next   = PAYLOAD_BITS'(payload);
                    state_next = src_ok ? S_RD : S_REJ;
                end
            end
            S_REJ:
            begin
                strobe_next = 1'b1;
                ost_next    = ST_STALE;
                olast_next  = 1'b1;
                state_next  = S_IDLE;
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                row_next   = rd_row;
                state_next = (op_reg == OP_FLUSH) ? S_FLUSH : S_EXEC;
            end
            S_EXEC:
            begin
                strobe_next = 1'b1;
                olast_next  = 1'b1;
                state_next  = S_IDLE;
                if (seq_gap == '0 || seq_gap[SEQ_BITS-1] || scan.dup)
                begin
                    ost_next = ST_STALE;
                end
                else if (seq_gap != SEQ_BITS'(1))
                begin
                    if (!scan.free_any)
                    begin
                        ost_next = ST_FULL;
                    end
                    else
                    begin
                        ost_next                    = ST_HELD;
                        row_next.vld[scan.free_idx] = 1'b1;
                        row_next.ent[scan.free_idx] = new_ent;
                        wb_next                     = 1'b1;
                    end
                end
                else
                begin
                    dlv_next          = 1'b1;
                    oroom_next        = room_reg;
                    opay_next         = PORT_PAY_BITS'(pay_reg);
                    oseq_next         = seq_reg;
                    olast_next        = !scan.hit2_any;
                    row_next.last_rel = seq_reg;
                    if (scan.hit2_any)
                    begin
                        state_next = S_CHAIN;
                    end
                    else
                    begin
                        wb_next = 1'b1;
                    end
                end
            end
            S_CHAIN:
            begin
                strobe_next                 = 1'b1;
                dlv_next                    = 1'b1;
                oroom_next                  = row_reg.ent[scan.hit1_idx].room;
                opay_next                   = PORT_PAY_BITS'(row_reg.ent[scan.hit1_idx].pay);
                oseq_next                   = row_reg.ent[scan.hit1_idx].seq;
                olast_next                  = !scan.hit2_any;
                row_next.vld[scan.hit1_idx] = 1'b0;
                row_next.last_rel           = row_reg.last_rel + SEQ_BITS'(1);
                if (!scan.hit2_any)
                begin
                    wb_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                strobe_next = 1'b1;
                if (!scan.any_valid)
                begin
                    olast_next        = 1'b1;
                    row_next.last_rel = '0;
                    wb_next           = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    dlv_next                   = 1'b1;
                    oroom_next                 = row_reg.ent[scan.min_idx].room;
                    opay_next                  = PORT_PAY_BITS'(row_reg.ent[scan.min_idx].pay);
                    oseq_next                  = row_reg.ent[scan.min_idx].seq;
                    olast_next                 = scan.one_valid;
                    row_next.vld[scan.min_idx] = 1'b0;
                    if (scan.one_valid)
                    begin
                        row_next.last_rel = '0;
                        wb_next           = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wb_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wb_reg     <= wb_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        src_reg   <= src_next;
        seq_reg   <= seq_next;
        room_reg  <= room_next;
        pay_reg   <= pay_next;
        row_reg   <= row_next;
        dlv_reg   <= dlv_next;
        oroom_reg <= oroom_next;
        opay_reg  <= opay_next;
        oseq_reg  <= oseq_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    // row write-back takes the cycle after the final beat is decided
    assign busy         = (state_reg != S_IDLE) || wb_reg;
    assign strobe       = strobe_reg;
    assign delivered    = dlv_reg;
    assign out_room     = oroom_reg;
    assign out_payload  = opay_reg;
    assign out_sequence = oseq_reg;
    assign status       = ost_reg;
    assign last         = olast_reg;

endmodule

### sim/fsrb_checker.sv
`timescale 1ns / 100ps
// fsrb_checker: predicts every result beat of the per-source reorder buffer and checks it
// depends on fsrb_pkg; instantiated beside the block by tb_fifo_sequence_reorder_buffer
module fsrb_checker
    import fsrb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     operation,
    input  logic [ID_BITS-1:0]       source_id,
    input  logic [SEQ_BITS-1:0]      sequence_req,
    input  logic [ROOM_BITS-1:0]     room,
    input  logic [PORT_PAY_BITS-1:0] payload,
    input  logic                     strobe,
    input  logic                     delivered,
    input  logic [ROOM_BITS-1:0]     out_room,
    input  logic [PORT_PAY_BITS-1:0] out_payload,
    input  logic [SEQ_BITS-1:0]      out_sequence,
    input  logic [1:0]               status,
    input  logic                     last,
    output int                       errors,
    output int                       outstanding
);

    typedef struct packed
    {
        logic                     dlv;
        logic [ROOM_BITS-1:0]     room;
        logic [PORT_PAY_BITS-1:0] pay;
        logic [SEQ_BITS-1:0]      seq;
        status_t                  st;
        logic                     lst;
    } beat_t;

    logic [SEQ_BITS-1:0] last_rel [NUM_SOURCES];
    logic                held     [NUM_SOURCES][HOLD_DEPTH];
    entry_t              slot     [NUM_SOURCES][HOLD_DEPTH];
    beat_t               expected_beats [$];
    int                  fails = 0;
    int                  pending = 0;

    assign errors      = fails;
    assign outstanding = pending;

    function automatic beat_t empty_beat(status_t st);
        beat_t b;
        b    = '0;
        b.st = st;
        return b;
    endfunction

    function automatic beat_t release_beat(entry_t e);
        beat_t b;
        b      = '0;
        b.dlv  = 1'b1;
        b.room = e.room;
        b.pay  = PORT_PAY_BITS'(e.pay);
        b.seq  = e.seq;
        b.st   = ST_DONE;
        return b;
    endfunction

    function automatic void predict_item(op_t op, int src, logic [SEQ_BITS-1:0] seq,
                                         logic [ROOM_BITS-1:0] rm,
                                         logic [PORT_PAY_BITS-1:0] pay);
        beat_t               run [HOLD_DEPTH + 1];
        int                  n;
        int                  best;
        int                  free_slot;
        bit                  dup;
        bit                  found;
        logic [SEQ_BITS-1:0] lr;
        logic [SEQ_BITS-1:0] gap_to;
        logic [SEQ_BITS-1:0] best_gap;
        logic [SEQ_BITS-1:0] want_seq;
        entry_t              e;
        n = 0;
        if (src >= NUM_SOURCES)
        begin
            run[0] = empty_beat(ST_STALE);
            n = 1;
        end
        else if (op == OP_FLUSH)
        begin
            lr = last_rel[src];
            do
            begin
                best     = -1;
                best_gap = '0;
                for (int i = 0; i < HOLD_DEPTH; i++)
                begin
                    if (held[src][i])
                    begin
                        gap_to = slot[src][i].seq - lr;
                        if (best < 0 || gap_to < best_gap)
                        begin
                            best     = i;
                            best_gap = gap_to;
                        end
                    end
                end
                if (best >= 0)
                begin
                    run[n] = release_beat(slot[src][best]);
                    n++;
                    held[src][best] = 1'b0;
                end
            end
            while (best >= 0);
            last_rel[src] = '0;
            if (n == 0)
            begin
                run[0] = empty_beat(ST_DONE);
                n = 1;
            end
        end
        else
        begin
            lr        = last_rel[src];
            gap_to    = seq - lr;
            dup       = 1'b0;
            free_slot = -1;
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (held[src][i])
                begin
                    if (slot[src][i].seq == seq)
                        dup = 1'b1;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            e.seq  = seq;
            e.room = rm;
            e.pay  = pay[PAYLOAD_BITS-1:0];
            n = 1;
            if (gap_to == 0 || gap_to[SEQ_BITS-1] || dup)
            begin
                run[0] = empty_beat(ST_STALE);
            end
            else if (gap_to != 1 && free_slot < 0)
            begin
                run[0] = empty_beat(ST_FULL);
            end
            else if (gap_to != 1)
            begin
                held[src][free_slot] = 1'b1;
                slot[src][free_slot] = e;
                run[0] = empty_beat(ST_HELD);
            end
            else
            begin
                run[0] = release_beat(e);
                lr = seq;
                do
                begin
                    found    = 1'b0;
                    want_seq = lr + 1'b1;
                    for (int i = 0; i < HOLD_DEPTH; i++)
                    begin
                        if (!found && held[src][i] && slot[src][i].seq == want_seq)
                        begin
                            run[n] = release_beat(slot[src][i]);
                            n++;
                            held[src][i] = 1'b0;
                            lr    = want_seq;
                            found = 1'b1;
                        end
                    end
                end
                while (found);
                last_rel[src] = lr;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            run[i].lst = (i == n - 1);
            expected_beats.insert(expected_beats.size(), run[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        beat_t got;
        beat_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                last_rel[s] = '0;
                for (int i = 0; i < HOLD_DEPTH; i++)
                    held[s][i] = 1'b0;
            end
            expected_beats.delete();
        end
        else
        begin
            if (strobe)
            begin
                got.dlv  = delivered;
                got.room = out_room;
                got.pay  = out_payload;
                got.seq  = out_sequence;
                got.st   = status_t'(status);
                got.lst  = last;
                if (expected_beats.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display({"%0t: beat with nothing expected: ",
                                  "dlv=%0d room=%0d pay=%h seq=%h st=%0d last=%0d"},
                                 $realtime, got.dlv, got.room, got.pay, got.seq, got.st,
                                 got.lst);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("%0t: beat mismatch", $realtime);
                            $display("  expected dlv=%0d room=%0d pay=%h seq=%h st=%0d last=%0d",
                                     want.dlv, want.room, want.pay, want.seq, want.st, want.lst);
                            $display("  actual   dlv=%0d room=%0d pay=%h seq=%h st=%0d last=%0d",
                                     got.dlv, got.room, got.pay, got.seq, got.st, got.lst);
                        end
                    end
                end
            end
            if (start && !busy)
                predict_item(op_t'(operation), int'(source_id), sequence_req, room, payload);
        end
        pending = expected_beats.size();
    end

endmodule

### sim/tb_fifo_sequence_reorder_buffer.sv
`timescale 1ns / 100ps
// tb_fifo_sequence_reorder_buffer: stimulus and verdict for the per-source reorder buffer
// depends on fsrb_pkg, fifo_sequence_reorder_buffer and fsrb_checker
module tb_fifo_sequence_reorder_buffer;
    import fsrb_pkg::*;

    localparam int                  RUN_ITEMS   = 75;
    localparam int                  CYCLE_LIMIT = 2_000_000;
    localparam logic [ID_BITS-1:0]  WRAP_SRC    = ID_BITS'(NUM_SOURCES - 1);

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [ID_BITS-1:0]       source_id;
    logic [SEQ_BITS-1:0]      sequence_req;
    logic [ROOM_BITS-1:0]     room;
    logic [PORT_PAY_BITS-1:0] payload;
    logic                     strobe;
    logic                     delivered;
    logic [ROOM_BITS-1:0]     out_room;
    logic [PORT_PAY_BITS-1:0] out_payload;
    logic [SEQ_BITS-1:0]      out_sequence;
    logic [1:0]               status;
    logic                     last;
    int                       errors;
    int                       outstanding;
    int                       items_sent = 0;
    int                       cycles = 0;
    bit                       quiet = 1'b0;
    logic [SEQ_BITS-1:0]      head [NUM_SOURCES];

    fifo_sequence_reorder_buffer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .source_id    (source_id),
        .sequence_req (sequence_req),
        .room         (room),
        .payload      (payload),
        .strobe       (strobe),
        .delivered    (delivered),
        .out_room     (out_room),
        .out_payload  (out_payload),
        .out_sequence (out_sequence),
        .status       (status),
        .last         (last)
    );

    fsrb_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .source_id    (source_id),
        .sequence_req (sequence_req),
        .room         (room),
        .payload      (payload),
        .strobe       (strobe),
        .delivered    (delivered),
        .out_room     (out_room),
        .out_payload  (out_payload),
        .out_sequence (out_sequence),
        .status       (status),
        .last         (last),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input op_t op, input logic [ID_BITS-1:0] src,
                         input logic [SEQ_BITS-1:0] seq, input logic [ROOM_BITS-1:0] rm,
                         input logic [PORT_PAY_BITS-1:0] pay);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation    = op;
        source_id    = src;
        sequence_req = seq;
        room         = rm;
        payload      = pay;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic arrive(input logic [ID_BITS-1:0] src, input logic [SEQ_BITS-1:0] seq);
        issue(OP_ARRIVE, src, seq, ROOM_BITS'($urandom_range(1, 10)), PORT_PAY_BITS'($urandom));
    endtask

    task automatic flush(input logic [ID_BITS-1:0] src);
        issue(OP_FLUSH, src, SEQ_BITS'($urandom), ROOM_BITS'($urandom_range(1, 10)),
              PORT_PAY_BITS'($urandom));
        head[src] = '0;
    endtask

    // hold the sender until every expected beat has come
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_shuffled(input logic [ID_BITS-1:0] src, input logic [SEQ_BITS-1:0] first,
                                 input int count, input int skip);
        logic [SEQ_BITS-1:0] order [HOLD_DEPTH + 1];
        logic [SEQ_BITS-1:0] t;
        int                  j;
        for (int i = 0; i < count; i++)
            order[i] = first + SEQ_BITS'(i);
        for (int i = count - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < count; i++)
            if (i != skip)
                arrive(src, order[i]);
    endtask

    // consecutive run in random order; a broken run loses one message and is flushed
    task automatic ordered_run(input logic [ID_BITS-1:0] src, input bit broken);
        int k;
        k = $urandom_range(1, HOLD_DEPTH + 1);
        if (!broken)
        begin
            send_shuffled(src, head[src] + 1'b1, k, -1);
            head[src] = head[src] + SEQ_BITS'(k);
        end
        else
        begin
            send_shuffled(src, head[src] + 1'b1, k, $urandom_range(0, k - 1));
            if ($urandom_range(0, 1))
                arrive(src, head[src] + SEQ_BITS'($urandom_range(1, k)));
            flush(src);
        end
    endtask

    task automatic overfill(input logic [ID_BITS-1:0] src);
        send_shuffled(src, head[src] + 2'd2, HOLD_DEPTH, -1);
        arrive(src, head[src] + SEQ_BITS'(HOLD_DEPTH + 2 + $urandom_range(0, 20)));
        if ($urandom_range(0, 1))
            arrive(src, head[src] + 1'b1);
        flush(src);
    endtask

    task automatic noise(input logic [ID_BITS-1:0] src);
        issue(op_t'($urandom_range(0, 1)), src, SEQ_BITS'($urandom),
              ROOM_BITS'($urandom_range(1, 10)), PORT_PAY_BITS'($urandom));
        flush(src);
    endtask

    initial
    begin
        int                 target;
        int                 pick;
        logic [ID_BITS-1:0] src;
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_ARRIVE;
        source_id    = '0;
        sequence_req = '0;
        room         = '0;
        payload      = '0;
        for (int s = 0; s < NUM_SOURCES; s++)
            head[s] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty flush, in order, stale, stale at half the range, farthest hold, duplicate
        issue(OP_FLUSH,  4'd0, 16'h0000, 4'd1,  16'h0000);
        issue(OP_ARRIVE, 4'd0, 16'h0001, 4'd1,  16'h0000);
        issue(OP_ARRIVE, 4'd0, 16'h0001, 4'd10, 16'hFFFF);
        issue(OP_ARRIVE, 4'd0, 16'h8001, 4'd10, 16'hFFFF);
        issue(OP_ARRIVE, 4'd0, 16'h8000, 4'd10, 16'hFFFF);
        issue(OP_ARRIVE, 4'd0, 16'h8000, 4'd1,  16'h0000);
        // full row, a refused arrival, then a release of the longest run; source 0 flushed
        for (int s = 2; s <= HOLD_DEPTH + 1; s++)
            issue(OP_ARRIVE, 4'd3, SEQ_BITS'(s), 4'd10, 16'hFFFF);
        issue(OP_ARRIVE, 4'd3, SEQ_BITS'(HOLD_DEPTH + 2), 4'd1, 16'h0000);
        issue(OP_ARRIVE, 4'd3, 16'h0001, 4'd10, 16'hFFFF);
        issue(OP_FLUSH,  4'd0, 16'hFFFF, 4'd10, 16'hFFFF);
        // flush releases out of slot order
        arrive(4'd5, 16'd7);
        arrive(4'd5, 16'd4);
        arrive(4'd5, 16'd6);
        flush(4'd5);
        flush(4'd3);
        flush(4'd0);
        drain();

        // distance wraps modulo the sequence space
        quiet = 1'b1;
        arrive(WRAP_SRC, 16'hFFFF);
        arrive(WRAP_SRC, 16'h8000);
        arrive(WRAP_SRC, 16'h7FFF);
        arrive(WRAP_SRC, 16'h0001);
        flush(WRAP_SRC);
        drain();

        target = items_sent + RUN_ITEMS;
        while (items_sent < target)
        begin
            src   = ID_BITS'($urandom_range(0, NUM_SOURCES - 1));
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                ordered_run(src, 1'b0);
            else if (pick < 75)
                ordered_run(src, 1'b1);
            else if (pick < 85)
                overfill(src);
            else
                noise(src);
        end

        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
